// ----- rtl/ctok_pkg.sv -----
// ----------------------------------------------------------------------------
// ctok_pkg: shared types and constants of the C source tokenizer
// Scanner states, token codes, the keyword table, and the result record
// that goes from the scanner through the result queue.
// ----------------------------------------------------------------------------
package ctok_pkg;

	// keyword buffer depth; no C keyword is longer than this
	localparam int KW_CHARS = 8;
	localparam int KW_IDX_W = $clog2(KW_CHARS);
	localparam int KW_COUNT = 32;
	localparam int LENGTH_LIMIT_DEF = 63;
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [4:0] {
		ST_START   = 5'd0,
		ST_IDENT   = 5'd1,
		ST_INT     = 5'd2,
		ST_DOT     = 5'd3,
		ST_FRAC    = 5'd4,
		ST_EXP     = 5'd5,
		ST_ESIGN   = 5'd6,
		ST_EDIG    = 5'd7,
		ST_LT      = 5'd8,
		ST_GT      = 5'd9,
		ST_EQ      = 5'd10,
		ST_PLUS    = 5'd11,
		ST_MINUS   = 5'd12,
		ST_AMP     = 5'd13,
		ST_BAR     = 5'd14,
		ST_SLASH   = 5'd15,
		ST_STAR    = 5'd16,
		ST_LINECMT = 5'd19
	} scan_state_t;

	// quote tracking
	localparam logic [1:0] QT_NONE   = 2'd0;
	localparam logic [1:0] QT_SINGLE = 2'd1;
	localparam logic [1:0] QT_DOUBLE = 2'd2;

	// token codes
	localparam logic [6:0] TK_HASH       = 7'd0;
	localparam logic [6:0] TK_LPAREN     = 7'd33;
	localparam logic [6:0] TK_RPAREN     = 7'd34;
	localparam logic [6:0] TK_LBRACK     = 7'd35;
	localparam logic [6:0] TK_RBRACK     = 7'd36;
	localparam logic [6:0] TK_ARROW      = 7'd37;
	localparam logic [6:0] TK_NOT        = 7'd38;
	localparam logic [6:0] TK_TILDE      = 7'd39;
	localparam logic [6:0] TK_INC        = 7'd40;
	localparam logic [6:0] TK_DEC        = 7'd41;
	localparam logic [6:0] TK_PLUS_MINUS = 7'd42;
	localparam logic [6:0] TK_STAR       = 7'd43;
	localparam logic [6:0] TK_AMP        = 7'd44;
	localparam logic [6:0] TK_SLASH      = 7'd45;
	localparam logic [6:0] TK_PERCENT    = 7'd46;
	localparam logic [6:0] TK_PLUS       = 7'd47;
	localparam logic [6:0] TK_MINUS      = 7'd48;
	localparam logic [6:0] TK_SHL        = 7'd49;
	localparam logic [6:0] TK_SHR        = 7'd50;
	localparam logic [6:0] TK_LT         = 7'd51;
	localparam logic [6:0] TK_LE         = 7'd52;
	localparam logic [6:0] TK_GE         = 7'd53;
	localparam logic [6:0] TK_GT         = 7'd54;
	localparam logic [6:0] TK_EQEQ       = 7'd55;
	localparam logic [6:0] TK_NE         = 7'd56;
	localparam logic [6:0] TK_XOR        = 7'd57;
	localparam logic [6:0] TK_BAR        = 7'd58;
	localparam logic [6:0] TK_LAND       = 7'd59;
	localparam logic [6:0] TK_LOR        = 7'd60;
	localparam logic [6:0] TK_ASSIGN     = 7'd61;
	localparam logic [6:0] TK_ADD_ASSIGN = 7'd62;
	localparam logic [6:0] TK_SUB_ASSIGN = 7'd63;
	localparam logic [6:0] TK_MUL_ASSIGN = 7'd64;
	localparam logic [6:0] TK_DIV_ASSIGN = 7'd65;
	localparam logic [6:0] TK_AND_ASSIGN = 7'd66;
	localparam logic [6:0] TK_XOR_ASSIGN = 7'd67;
	localparam logic [6:0] TK_OR_ASSIGN  = 7'd68;
	localparam logic [6:0] TK_SHL_ASSIGN = 7'd69;
	localparam logic [6:0] TK_SHR_ASSIGN = 7'd70;
	localparam logic [6:0] TK_COMMA      = 7'd71;
	localparam logic [6:0] TK_SEMI       = 7'd72;
	localparam logic [6:0] TK_SQUOTE     = 7'd73;
	localparam logic [6:0] TK_DOT        = 7'd74;
	localparam logic [6:0] TK_DQUOTE     = 7'd75;
	localparam logic [6:0] TK_COLON      = 7'd76;
	localparam logic [6:0] TK_LBRACE     = 7'd77;
	localparam logic [6:0] TK_RBRACE     = 7'd78;
	localparam logic [6:0] TK_IDENT      = 7'd79;
	localparam logic [6:0] TK_NUMBER     = 7'd80;
	localparam logic [6:0] TK_BLK_OPEN   = 7'd81;
	localparam logic [6:0] TK_BLK_CLOSE  = 7'd82;
	localparam logic [6:0] TK_LINE_CMT   = 7'd83;
	localparam logic [6:0] TK_MAX        = 7'd83;

	// keyword text, right-justified: first char in the highest used byte
	localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
		64'("auto"), 64'("double"), 64'("int"), 64'("struct"),
		64'("break"), 64'("else"), 64'("long"), 64'("switch"),
		64'("case"), 64'("enum"), 64'("register"), 64'("typedef"),
		64'("char"), 64'("extern"), 64'("return"), 64'("union"),
		64'("const"), 64'("float"), 64'("short"), 64'("unsigned"),
		64'("continue"), 64'("for"), 64'("signed"), 64'("void"),
		64'("default"), 64'("goto"), 64'("sizeof"), 64'("volatile"),
		64'("do"), 64'("while"), 64'("static"), 64'("if")
	};
	localparam int KW_LEN [KW_COUNT] = '{
		4, 6, 3, 6, 5, 4, 4, 6, 4, 4, 8, 7, 4, 6, 6, 5,
		5, 5, 5, 8, 8, 3, 6, 4, 7, 4, 6, 8, 2, 5, 6, 2
	};

	typedef struct packed {
		logic       is_error;
		logic [6:0] token_code;
		logic [5:0] token_length;
		logic       last;
	} result_t;

	// up to two results of one input transaction, in order
	typedef struct packed {
		logic    v0;
		logic    v1;
		result_t r0;
		result_t r1;
	} scan_res_t;

endpackage

// ----- rtl/c_source_tokenizer.sv -----
// ----------------------------------------------------------------------------
// c_source_tokenizer: C lexical analyzer, one source byte per cycle
// Input queue side: push with character/line_break, held off by full.
// Result queue side: empty low shows the oldest result; pop takes it.
// Each input transaction yields zero, one or two results; last marks the
// final result of a transaction. A result is registered in the queue and
// shown once oldest. The scanner takes one transaction per cycle while
// full is low; its state update is a combinational decode plus keyword
// compare. The result queue holds four entries and full rises while fewer
// than two are free, so a stalled receiver holds the input side after at
// most three results are waiting. Items yielding two results need two pops.
// Reset (arst_n low) returns the scanner to its start state, outside any
// quote or comment, and empties the result queue.
// ----------------------------------------------------------------------------
module c_source_tokenizer #(
	parameter int LengthLimit = ctok_pkg::LENGTH_LIMIT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] character,
	input  logic       line_break,
	output logic       empty,
	input  logic       pop,
	output logic       is_error,
	output logic [6:0] token_code,
	output logic [5:0] token_length,
	output logic       last
);
	import ctok_pkg::*;

	logic      take;
	scan_res_t res;
	result_t   head;

	assign take = push && !full;

	ctok_scan #(.LengthLimit(LengthLimit)) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.character  (character),
		.line_break (line_break),
		.res        (res)
	);

	ctok_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.res    (res),
		.pop    (pop),
		.empty  (empty),
		.full   (full),
		.head   (head)
	);

	assign is_error     = head.is_error;
	assign token_code   = head.token_code;
	assign token_length = head.token_length;
	assign last         = head.last;

	// a second result never comes without a first
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		res.v1 |-> res.v0 && !res.r0.last && res.r1.last)
		else $error("second result without first");

	// the final result of a transaction carries last
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		res.v0 && !res.v1 |-> res.r0.last)
		else $error("single result not marked last");

	// error results carry code zero and length one
	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && is_error |-> token_code == TK_HASH && token_length == 6'd1)
		else $error("malformed error result");

	// codes stay in the defined range
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> token_code <= TK_MAX)
		else $error("token code out of range");

endmodule

// ----- rtl/ctok_scan.sv -----
// ----------------------------------------------------------------------------
// ctok_scan: front end of the tokenizer
// Holds the scanner state and turns one accepted transaction into zero,
// one or two result records combinationally.
// ----------------------------------------------------------------------------
module ctok_scan #(
	parameter int LengthLimit = ctok_pkg::LENGTH_LIMIT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [7:0]          character,
	input  logic                line_break,
	output ctok_pkg::scan_res_t res
);
	import ctok_pkg::*;

	localparam int LW = $clog2(LengthLimit + 1);
	localparam logic [LW-1:0] LIM = LW'(LengthLimit);

	scan_state_t   st_q, n_st;
	logic [LW-1:0] len_q, n_len;
	logic [7:0]    fop_q, n_fop;
	logic          blk_q, n_blk;
	logic [1:0]    quo_q, n_quo;
	logic [7:0]    nbuf_q [KW_CHARS];

	logic [7:0] c;
	logic       is_alpha, is_num, is_idc;
	assign c        = character;
	assign is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	assign is_num   = c >= "0" && c <= "9";
	assign is_idc   = is_alpha || is_num || c == "_";

	// keyword lookup on the buffered name
	logic [6:0] id_code;
	always_comb begin
		logic hit;
		id_code = TK_IDENT;
		for (int k = 0; k < KW_COUNT; k++) begin
			hit = (int'(len_q) == KW_LEN[k]);
			for (int i = 0; i < KW_CHARS; i++) begin
				if (i < KW_LEN[k] && nbuf_q[i] != KW_TEXT[k][(KW_LEN[k] - 1 - i) * 8 +: 8])
					hit = 1'b0;
			end
			if (hit)
				id_code = 7'(k);
		end
	end

	// codes of ^ = ! (single and with trailing '=') and of << >> (bare and with trailing '=')
	logic [6:0] eq1_code, eq2_code;
	always_comb begin
		case (fop_q)
			"^": begin eq1_code = TK_XOR;    eq2_code = TK_XOR_ASSIGN; end
			"=": begin eq1_code = TK_ASSIGN; eq2_code = TK_EQEQ;       end
			"!": begin eq1_code = TK_NOT;    eq2_code = TK_NE;         end
			"<": begin eq1_code = TK_SHL;    eq2_code = TK_SHL_ASSIGN; end
			default: begin eq1_code = TK_SHR; eq2_code = TK_SHR_ASSIGN; end
		endcase
	end

	// token pending in the current state
	logic       pend_v;
	logic [6:0] pend_code;
	always_comb begin
		pend_v    = 1'b1;
		pend_code = TK_HASH;
		case (st_q)
			ST_IDENT: pend_code = id_code;
			ST_INT, ST_DOT, ST_FRAC, ST_EXP, ST_ESIGN, ST_EDIG: pend_code = TK_NUMBER;
			ST_LT:    pend_code = TK_LT;
			ST_GT:    pend_code = TK_GT;
			ST_EQ:    pend_code = eq1_code;
			ST_PLUS:  pend_code = TK_PLUS;
			ST_MINUS: pend_code = TK_MINUS;
			ST_AMP:   pend_code = TK_AMP;
			ST_BAR:   pend_code = TK_BAR;
			ST_SLASH: pend_code = TK_SLASH;
			ST_STAR:  pend_code = TK_STAR;
			default:  pend_v = 1'b0;
		endcase
	end

	// start-state decode of the character
	scan_state_t sc_st;
	logic        sc_app, sc_emit, sc_err;
	logic [6:0]  sc_code;
	logic [1:0]  sc_quo;
	always_comb begin
		sc_st   = ST_START;
		sc_app  = 1'b1;
		sc_emit = 1'b0;
		sc_err  = 1'b0;
		sc_code = TK_HASH;
		sc_quo  = QT_NONE;
		if (is_alpha || c == "_") begin
			sc_st = ST_IDENT;
		end else if (is_num) begin
			sc_st = ST_INT;
		end else begin
			case (c)
				"<":           sc_st = ST_LT;
				">":           sc_st = ST_GT;
				"^", "=", "!": sc_st = ST_EQ;
				"+":           sc_st = ST_PLUS;
				"-":           sc_st = ST_MINUS;
				"&":           sc_st = ST_AMP;
				"|":           sc_st = ST_BAR;
				"/":           sc_st = ST_SLASH;
				"*":           sc_st = ST_STAR;
				default: begin
					sc_app  = 1'b0;
					sc_emit = 1'b1;
					case (c)
						" ", 8'h09: sc_emit = 1'b0;
						8'h27: begin sc_code = TK_SQUOTE; sc_quo = QT_SINGLE; end
						8'h22: begin sc_code = TK_DQUOTE; sc_quo = QT_DOUBLE; end
						",": sc_code = TK_COMMA;
						";": sc_code = TK_SEMI;
						"{": sc_code = TK_LBRACE;
						"}": sc_code = TK_RBRACE;
						"(": sc_code = TK_LPAREN;
						")": sc_code = TK_RPAREN;
						"[": sc_code = TK_LBRACK;
						"]": sc_code = TK_RBRACK;
						"~": sc_code = TK_TILDE;
						"#": sc_code = TK_HASH;
						".": sc_code = TK_DOT;
						"%": sc_code = TK_PERCENT;
						":": sc_code = TK_COLON;
						default: sc_err = 1'b1;
					endcase
				end
			endcase
		end
	end

	// transition and result slots: slot a first, slot b from a rescan
	logic          a_want, a_force, a_err, b_want, b_err;
	logic [6:0]    a_code, b_code;
	logic [5:0]    a_len;
	logic          app, fin, rescan, start, wr_en;
	logic [6:0]    fin_code;
	logic [LW-1:0] app_len;
	logic [KW_IDX_W-1:0] wr_idx;
	result_t       ra, rb;
	logic          va, vb;

	assign app_len = (len_q < LIM) ? len_q + 1'b1 : len_q;

	always_comb begin
		n_st = st_q; n_len = len_q; n_fop = fop_q; n_blk = blk_q; n_quo = quo_q;
		a_want = 1'b0; a_force = 1'b0; a_err = 1'b0; a_code = TK_HASH; a_len = 6'd0;
		b_want = 1'b0; b_err = 1'b0; b_code = TK_HASH;
		app = 1'b0; fin = 1'b0; fin_code = TK_HASH; rescan = 1'b0; start = 1'b0;
		wr_en = 1'b0; wr_idx = '0;
		if (line_break) begin
			a_want = pend_v; a_code = pend_code; a_len = 6'(len_q);
			n_st = ST_START; n_quo = QT_NONE;
		end else if (quo_q != QT_NONE) begin
			if ((quo_q == QT_SINGLE && c == 8'h27) || (quo_q == QT_DOUBLE && c == 8'h22)) begin
				a_want = 1'b1; a_len = 6'd1;
				a_code = (quo_q == QT_SINGLE) ? TK_SQUOTE : TK_DQUOTE;
				n_quo  = QT_NONE;
			end
		end else begin
			case (st_q)
				ST_IDENT: if (is_idc) app = 1'b1; else rescan = 1'b1;
				ST_INT: begin
					if (is_num) app = 1'b1;
					else if (c == ".") begin app = 1'b1; n_st = ST_DOT; end
					else if (c == "E") begin app = 1'b1; n_st = ST_EXP; end
					else rescan = 1'b1;
				end
				ST_DOT: begin app = 1'b1; n_st = ST_FRAC; end
				ST_FRAC: begin
					if (is_num) app = 1'b1;
					else if (c == "E") begin app = 1'b1; n_st = ST_EXP; end
					else rescan = 1'b1;
				end
				ST_EXP: begin
					app = 1'b1;
					if (c == "+" || c == "-") n_st = ST_ESIGN;
					else if (is_num) n_st = ST_EDIG;
				end
				ST_ESIGN: begin app = 1'b1; n_st = ST_EDIG; end
				ST_EDIG: if (is_num) app = 1'b1; else rescan = 1'b1;
				ST_LT, ST_GT: begin
					if (c == fop_q) begin app = 1'b1; n_st = ST_EQ; end
					else if (c == "=") begin
						fin = 1'b1; fin_code = (st_q == ST_LT) ? TK_LE : TK_GE;
					end else rescan = 1'b1;
				end
				ST_EQ: if (c == "=") begin fin = 1'b1; fin_code = eq2_code; end
					else rescan = 1'b1;
				ST_PLUS: begin
					fin = 1'b1;
					case (c)
						"-": fin_code = TK_PLUS_MINUS;
						"+": fin_code = TK_INC;
						"=": fin_code = TK_ADD_ASSIGN;
						default: begin fin = 1'b0; rescan = 1'b1; end
					endcase
				end
				ST_MINUS: begin
					fin = 1'b1;
					case (c)
						"-": fin_code = TK_DEC;
						">": fin_code = TK_ARROW;
						"=": fin_code = TK_SUB_ASSIGN;
						default: begin fin = 1'b0; rescan = 1'b1; end
					endcase
				end
				ST_AMP: begin
					fin = 1'b1;
					case (c)
						"&": fin_code = TK_LAND;
						"=": fin_code = TK_AND_ASSIGN;
						default: begin fin = 1'b0; rescan = 1'b1; end
					endcase
				end
				ST_BAR: begin
					fin = 1'b1;
					case (c)
						"|": fin_code = TK_LOR;
						"=": fin_code = TK_OR_ASSIGN;
						default: begin fin = 1'b0; rescan = 1'b1; end
					endcase
				end
				ST_SLASH: begin
					fin = 1'b1;
					case (c)
						"=": fin_code = TK_DIV_ASSIGN;
						"/": fin_code = TK_LINE_CMT;
						"*": begin fin_code = TK_BLK_OPEN; n_blk = 1'b1; end
						default: begin fin = 1'b0; rescan = 1'b1; end
					endcase
				end
				ST_STAR: begin
					fin = 1'b1;
					case (c)
						"/": begin fin_code = TK_BLK_CLOSE; a_force = 1'b1; n_blk = 1'b0; end
						"=": fin_code = TK_MUL_ASSIGN;
						default: begin fin = 1'b0; rescan = 1'b1; end
					endcase
				end
				ST_LINECMT: ;
				default: start = 1'b1;
			endcase

			// extend the current token by one character, length saturating at the limit
			if (app || fin) begin
				n_len = app_len;
				if (len_q < LW'(KW_CHARS)) begin
					wr_en = 1'b1; wr_idx = len_q[KW_IDX_W-1:0];
				end
			end
			if (fin) begin
				a_want = 1'b1; a_code = fin_code; a_len = 6'(app_len);
				n_st = (st_q == ST_SLASH && c == "/") ? ST_LINECMT : ST_START;
			end
			if (rescan) begin
				a_want = pend_v; a_code = pend_code; a_len = 6'(len_q);
			end

			// scan the character from the start state
			if (rescan || start) begin
				n_st  = sc_st;
				n_fop = c;
				n_len = sc_app ? LW'(1) : '0;
				n_quo = sc_quo;
				if (sc_app) begin wr_en = 1'b1; wr_idx = '0; end
				if (start) begin
					a_want = sc_emit; a_err = sc_err; a_len = 6'd1;
					a_code = sc_err ? TK_HASH : sc_code;
				end else begin
					b_want = sc_emit; b_err = sc_err;
					b_code = sc_err ? TK_HASH : sc_code;
				end
			end
		end
	end

	// block comment gating and packing into result order
	assign va = a_want && (!blk_q || a_force);
	assign vb = b_want && !blk_q;
	assign ra = '{is_error: a_err, token_code: a_code, token_length: a_len, last: !vb};
	assign rb = '{is_error: b_err, token_code: b_code, token_length: 6'd1, last: 1'b1};

	always_comb begin
		res.v0 = va || vb;
		res.v1 = va && vb;
		res.r0 = va ? ra : rb;
		res.r1 = rb;
	end

	// scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_START;
			len_q <= '0;
			fop_q <= '0;
			blk_q <= 1'b0;
			quo_q <= QT_NONE;
		end else if (take) begin
			st_q  <= n_st;
			len_q <= n_len;
			fop_q <= n_fop;
			blk_q <= n_blk;
			quo_q <= n_quo;
		end
	end

	// name buffer, payload only
	always_ff @(posedge clk) begin
		if (take && wr_en)
			nbuf_q[wr_idx] <= c;
	end

endmodule

// ----- rtl/ctok_queue.sv -----
// ----------------------------------------------------------------------------
// ctok_queue: back end result queue
// Takes up to two results per cycle from the scanner and hands them out
// one per pop, oldest first.
// ----------------------------------------------------------------------------
module ctok_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  ctok_pkg::scan_res_t res,
	input  logic                pop,
	output logic                empty,
	output logic                full,
	output ctok_pkg::result_t   head
);
	import ctok_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	result_t       mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wp_q, rp_q, wp1;
	logic [CW-1:0] cnt_q;
	logic          do_pop;
	logic [1:0]    n_push;

	// keep room for a two-result transaction
	assign full   = cnt_q > CW'(QUEUE_DEPTH - 2);
	assign empty  = cnt_q == '0;
	assign head   = mem_q[rp_q];
	assign do_pop = pop && !empty;
	assign wp1    = wp_q + 1'b1;
	assign n_push = take ? (2'(res.v0) + 2'(res.v1)) : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + PW'(n_push);
			rp_q  <= rp_q + PW'(do_pop);
			cnt_q <= cnt_q + CW'(n_push) - CW'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (take && res.v0)
			mem_q[wp_q] <= res.r0;
		if (take && res.v1)
			mem_q[wp1] <= res.r1;
	end

endmodule
